// ===== rtl/core/order_flow_imbalance_event_filter_macros.svh =====
// assertion macros for the order flow imbalance event filter
`ifndef ORDER_FLOW_IMBALANCE_EVENT_FILTER_MACROS_SVH
`define ORDER_FLOW_IMBALANCE_EVENT_FILTER_MACROS_SVH

// property that holds in the cycle after the antecedent
`define OFI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// property that holds in the same cycle
`define OFI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ofi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofi_pkg
// shared types and constants of the order flow imbalance event filter
// ----------------------------------------------------------------------------
package ofi_pkg;

   localparam int MarketSlots = 16;
   localparam int SlotW = $clog2(MarketSlots);

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_STALE   = 3'd2;
   localparam logic [2:0] ST_ORDER   = 3'd3;
   localparam logic [2:0] ST_BADKEY  = 3'd4;

   localparam logic [1:0] GAP_UNKNOWN = 2'd0;
   localparam logic [1:0] GAP_NONE    = 2'd1;
   localparam logic [1:0] GAP_SEEN    = 2'd2;

   localparam logic [48:0] AgeReset = 49'd1000000000;
   localparam logic [31:0] CntMax = 32'hFFFF_FFFF;

   // classified event from front to back
   typedef struct packed {
      logic          is_trade;
      logic          invalid;     // book update failed field checks
      logic          trade_bad;   // trade failed field checks
      logic          stale;
      logic          no_slot;
      logic [SlotW-1:0] slot;
      logic signed [63:0] rtime;
      logic [31:0]   bid;
      logic [30:0]   bsz;
      logic [31:0]   ask;
      logic [30:0]   asz;
      logic [1:0]    gap;
      logic          aggr;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot_index;
      logic [33:0] flow_imbalance;
      logic [30:0] bid_drain;
      logic [30:0] bid_fill;
      logic [30:0] ask_drain;
      logic [30:0] ask_fill;
      logic [32:0] mid_doubled;
      logic [1:0]  gap_state;
      logic        aggr_buy;
      logic [31:0] out_of_order_count;
      logic [31:0] stale_count;
   } rsp_type;

   function automatic logic [30:0] clamp_size(input logic [31:0] v);
      clamp_size = v[31] ? 31'd0 : v[30:0];
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] c);
      sat_inc = (c == CntMax) ? c : c + 32'd1;
   endfunction

endpackage

// ===== rtl/core/order_flow_imbalance_event_filter.sv =====
`timescale 1ns / 1ps
// path: a request passes the front register, then the back register, before rsp_tvalid
// throughput: one event per cycle unless rsp_tready back-pressure stalls it; front matches the slot, back updates it
// reset: synchronous, clears slot table, times, quote flags and counters, max age to default
// ----------------------------------------------------------------------------
// order_flow_imbalance_event_filter
// per-market level-1 order flow imbalance event filter
// ----------------------------------------------------------------------------
module order_flow_imbalance_event_filter (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // market_key, receive_time, exchange_time, bid_price, bid_quantity,
   // ask_price, ask_quantity, gap_indicator, trade_price, trade_quantity,
   // buyer_is_maker, zero pad
   input  logic [399:0] req_tdata,
   input  logic         req_tuser, // mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, slot_index, flow_imbalance, bid drain, bid fill,
   // ask drain, ask fill, mid_doubled, gap_state, aggressor buy flag,
   // out_of_order_count, stale_count, zero pad
   output logic [271:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [48:0]  csr_data
);
   import ofi_pkg::*;

   logic [48:0] age_ff;
   logic        cmd_valid, cmd_ready;
   cmd_type     cmd;
   rsp_type     rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff <= AgeReset;
      end else if (csr_valid) begin
         age_ff <= csr_data;
      end
   end

   ofi_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .mode           (req_tuser),
      .market_key     (req_tdata[63:0]),
      .receive_time   (req_tdata[127:64]),
      .exchange_time  (req_tdata[191:128]),
      .bid_price      (req_tdata[223:192]),
      .bid_quantity   (req_tdata[255:224]),
      .ask_price      (req_tdata[287:256]),
      .ask_quantity   (req_tdata[319:288]),
      .gap_indicator  (req_tdata[327:320]),
      .trade_price    (req_tdata[359:328]),
      .trade_quantity (req_tdata[391:360]),
      .buyer_is_maker (req_tdata[392]),
      .max_age        (age_ff),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd            (cmd)
   );

   ofi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {
      7'd0, rsp.stale_count, rsp.out_of_order_count, rsp.aggr_buy, rsp.gap_state,
      rsp.mid_doubled, rsp.ask_fill, rsp.ask_drain, rsp.bid_fill,
      rsp.bid_drain, rsp.flow_imbalance, rsp.slot_index, rsp.status};
endmodule

// ===== rtl/core/ofi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofi_front
// validates events, matches or allocates the market slot, checks trade age
// ----------------------------------------------------------------------------
`include "order_flow_imbalance_event_filter_macros.svh"
module ofi_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                mode,
   input  logic [63:0]         market_key,
   input  logic signed [63:0]  receive_time,
   input  logic signed [63:0]  exchange_time,
   input  logic [31:0]         bid_price,
   input  logic [31:0]         bid_quantity,
   input  logic [31:0]         ask_price,
   input  logic [31:0]         ask_quantity,
   input  logic [7:0]          gap_indicator,
   input  logic [31:0]         trade_price,
   input  logic [31:0]         trade_quantity,
   input  logic                buyer_is_maker,
   input  logic [48:0]         max_age,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output ofi_pkg::cmd_type    cmd
);
   import ofi_pkg::*;

   logic [63:0]            key_ff [MarketSlots];
   logic [MarketSlots-1:0] used_ff, used_in;
   logic                   cmd_valid_ff;
   cmd_type                cmd_ff, cmd_in;
   logic                   take;
   logic                   hit, has_free, book_bad, tr_bad, stale;
   logic [SlotW-1:0]       hit_idx, free_idx;
   logic signed [64:0]     age;

   assign in_ready = !cmd_valid_ff || cmd_ready;
   assign take = in_valid && in_ready;

   always_comb begin
      hit = 1'b0;
      hit_idx = '0;
      has_free = 1'b0;
      free_idx = '0;
      for (int i = MarketSlots - 1; i >= 0; i--) begin
         if (used_ff[i] && key_ff[i] == market_key) begin
            hit = 1'b1;
            hit_idx = SlotW'(i);
         end
         if (!used_ff[i]) begin
            has_free = 1'b1;
            free_idx = SlotW'(i);
         end
      end
      book_bad = (receive_time <= 64'sd0) || (bid_price == 32'd0) ||
                 (ask_price <= bid_price);
      tr_bad = (receive_time <= 64'sd0) || (trade_price == 32'd0) ||
               ($signed(trade_quantity) <= 32'sd0);
      age = {receive_time[63], receive_time} - {exchange_time[63], exchange_time};
      stale = (exchange_time > 64'sd0) && (receive_time >= exchange_time) &&
              (age > $signed({16'd0, max_age}));
      cmd_in.is_trade = mode;
      cmd_in.invalid = !mode && book_bad;
      cmd_in.trade_bad = tr_bad;
      cmd_in.stale = stale;
      cmd_in.no_slot = (market_key == 64'd0) || (!hit && !has_free);
      cmd_in.slot = hit ? hit_idx : free_idx;
      cmd_in.rtime = receive_time;
      cmd_in.bid = bid_price;
      cmd_in.bsz = clamp_size(bid_quantity);
      cmd_in.ask = ask_price;
      cmd_in.asz = clamp_size(ask_quantity);
      cmd_in.gap = $signed(gap_indicator) < 8'sd0 ? GAP_UNKNOWN :
                   (gap_indicator == 8'd0 ? GAP_NONE : GAP_SEEN);
      cmd_in.aggr = !buyer_is_maker;
      used_in = used_ff;
      if (take && !cmd_in.invalid && !cmd_in.no_slot && !hit) begin
         used_in[free_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         cmd_valid_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         if (in_ready) begin
            cmd_valid_ff <= in_valid;
         end
      end
      if (take) begin
         cmd_ff <= cmd_in;
         if (!cmd_in.invalid && !cmd_in.no_slot && !hit) begin
            key_ff[free_idx] <= market_key;
         end
      end
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd = cmd_ff;

   `OFI_ASSERT_NEXT(a_used_grows, clock, reset, 1'b1,
      (used_ff & $past(used_ff)) == $past(used_ff), "slot freed unexpectedly")
   `OFI_ASSERT_NEXT(a_hold, clock, reset, cmd_valid_ff && !cmd_ready,
      cmd_valid_ff && $stable(cmd_ff), "command changed while stalled")
   `OFI_ASSERT_SAME(a_zero_key, clock, reset, take && market_key == 64'd0,
      cmd_in.no_slot, "zero key accepted")
endmodule

// ===== rtl/core/ofi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofi_back
// per-slot quote state, order check, imbalance and saturating counters
// ----------------------------------------------------------------------------
`include "order_flow_imbalance_event_filter_macros.svh"
module ofi_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  ofi_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ofi_pkg::rsp_type rsp
);
   import ofi_pkg::*;

   logic signed [63:0] last_ff [MarketSlots];
   logic [31:0]        dis_ff [MarketSlots];
   logic [31:0]        stc_ff [MarketSlots];
   logic [31:0]        pbp_ff [MarketSlots];
   logic [30:0]        pbs_ff [MarketSlots];
   logic [31:0]        pap_ff [MarketSlots];
   logic [30:0]        pas_ff [MarketSlots];
   logic [MarketSlots-1:0] hq_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               take, ooo, upd_book, upd_trade, inc_d, inc_s;
   logic signed [33:0] bc, ac;
   logic [31:0]        dis_n, stc_n;
   logic [SlotW-1:0]   s;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign take = cmd_valid && cmd_ready;
   assign s = cmd.slot;

   always_comb begin
      ooo = cmd.rtime < last_ff[s];
      upd_book = 1'b0;
      upd_trade = 1'b0;
      inc_d = 1'b0;
      inc_s = 1'b0;
      bc = '0;
      ac = '0;
      rsp_in = '0;
      if (!cmd.is_trade && cmd.invalid) begin
         rsp_in.status = ST_INVALID;
      end else if (cmd.no_slot) begin
         rsp_in.status = ST_BADKEY;
      end else if (cmd.is_trade && cmd.trade_bad) begin
         rsp_in.status = ST_INVALID;
      end else if (cmd.is_trade && cmd.stale) begin
         rsp_in.status = ST_STALE;
         inc_s = 1'b1;
      end else if (ooo) begin
         rsp_in.status = ST_ORDER;
         inc_d = 1'b1;
      end else if (cmd.is_trade) begin
         rsp_in.status = ST_OK;
         rsp_in.aggr_buy = cmd.aggr;
         upd_trade = 1'b1;
      end else begin
         rsp_in.status = ST_OK;
         upd_book = 1'b1;
         if (hq_ff[s]) begin
            if (cmd.bid > pbp_ff[s]) begin
               bc = 34'(cmd.bsz);
               rsp_in.bid_fill = cmd.bsz;
            end else if (cmd.bid < pbp_ff[s]) begin
               bc = -34'(pbs_ff[s]);
               rsp_in.bid_drain = pbs_ff[s];
            end else begin
               bc = 34'(cmd.bsz) - 34'(pbs_ff[s]);
               if (bc < 0) rsp_in.bid_drain = 31'(-bc);
               else rsp_in.bid_fill = 31'(bc);
            end
            if (cmd.ask < pap_ff[s]) begin
               ac = -34'(cmd.asz);
               rsp_in.ask_fill = cmd.asz;
            end else if (cmd.ask > pap_ff[s]) begin
               ac = 34'(pas_ff[s]);
               rsp_in.ask_drain = pas_ff[s];
            end else begin
               ac = 34'(pas_ff[s]) - 34'(cmd.asz);
               if (ac > 0) rsp_in.ask_drain = 31'(ac);
               else rsp_in.ask_fill = 31'(-ac);
            end
         end
         rsp_in.flow_imbalance = bc + ac;
         rsp_in.mid_doubled = {1'b0, cmd.bid} + {1'b0, cmd.ask};
         rsp_in.gap_state = cmd.gap;
      end
      dis_n = inc_d ? sat_inc(dis_ff[s]) : dis_ff[s];
      stc_n = inc_s ? sat_inc(stc_ff[s]) : stc_ff[s];
      if (!(cmd.no_slot || (!cmd.is_trade && cmd.invalid))) begin
         rsp_in.slot_index = 4'(s);
         rsp_in.out_of_order_count = dis_n;
         rsp_in.stale_count = stc_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hq_ff <= '0;
         for (int i = 0; i < MarketSlots; i++) begin
            last_ff[i] <= '0;
            dis_ff[i] <= '0;
            stc_ff[i] <= '0;
         end
      end else begin
         if (cmd_ready) begin
            rsp_valid_ff <= cmd_valid;
         end
         if (take) begin
            dis_ff[s] <= dis_n;
            stc_ff[s] <= stc_n;
            if (upd_book || upd_trade) begin
               last_ff[s] <= cmd.rtime;
            end
            if (upd_book) begin
               hq_ff[s] <= 1'b1;
            end
         end
      end
      if (take) begin
         rsp_ff <= rsp_in;
         if (upd_book) begin
            pbp_ff[s] <= cmd.bid;
            pbs_ff[s] <= cmd.bsz;
            pap_ff[s] <= cmd.ask;
            pas_ff[s] <= cmd.asz;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   `OFI_ASSERT_SAME(a_one_inc, clock, reset, take, !(inc_d && inc_s),
      "two counters bumped by one event")
   `OFI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp_ready,
      rsp_valid_ff && $stable(rsp_ff), "result changed while stalled")
   `OFI_ASSERT_SAME(a_ok_fields, clock, reset, rsp_valid_ff && rsp_ff.status != ST_OK,
      rsp_ff.aggr_buy == 1'b0 && rsp_ff.gap_state == GAP_UNKNOWN,
      "rejected event carries accepted fields")
endmodule
